>>> rtl/jsv_pkg.sv
// shared types, constants and byte helpers for the json syntax validator
`default_nettype none

package jsv_pkg;

    // default container stack depth
    localparam int unsigned MAX_DEPTH_DEFAULT = 32;
    // entries in the byte queue between front and back (power of two)
    localparam int unsigned QUEUE_DEPTH = 4;

    // character codes
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_LF      = 8'h0A;
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_LBRACE  = 8'h7B;
    localparam logic [7:0] CHR_RBRACE  = 8'h7D;
    localparam logic [7:0] CHR_LBRACK  = 8'h5B;
    localparam logic [7:0] CHR_RBRACK  = 8'h5D;
    localparam logic [7:0] CHR_QUOTE   = 8'h22;
    localparam logic [7:0] CHR_COMMA   = 8'h2C;
    localparam logic [7:0] CHR_COLON   = 8'h3A;
    localparam logic [7:0] CHR_T       = 8'h74;
    localparam logic [7:0] CHR_F       = 8'h66;
    localparam logic [7:0] CHR_N       = 8'h6E;
    localparam logic [7:0] CHR_R       = 8'h72;
    localparam logic [7:0] CHR_U       = 8'h75;
    localparam logic [7:0] CHR_E       = 8'h65;
    localparam logic [7:0] CHR_A       = 8'h61;
    localparam logic [7:0] CHR_L       = 8'h6C;
    localparam logic [7:0] CHR_S       = 8'h73;
    localparam logic [7:0] CHR_NUL     = 8'h00;

    typedef enum logic [3:0] {
        PH_TOP,
        PH_ARR_FIRST,
        PH_ARR_COMMA,
        PH_VALUE,
        PH_OBJ_FIRST,
        PH_OBJ_COMMA,
        PH_KEY,
        PH_IN_KEY,
        PH_COLON,
        PH_IN_STRING,
        PH_NUMBER,
        PH_LITERAL,
        PH_AFTER
    } phase_t;

    typedef enum logic [3:0] {
        CLS_WS,
        CLS_DIGIT,
        CLS_OBJ_OPEN,
        CLS_OBJ_CLOSE,
        CLS_ARR_OPEN,
        CLS_ARR_CLOSE,
        CLS_QUOTE,
        CLS_COMMA,
        CLS_COLON,
        CLS_LIT_T,
        CLS_LIT_F,
        CLS_LIT_N,
        CLS_OTHER
    } byte_class_t;

    typedef enum logic {
        KIND_OBJ = 1'b0,
        KIND_ARR = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        LIT_TRUE,
        LIT_FALSE,
        LIT_NULL
    } lit_kind_t;

    typedef enum logic [3:0] {
        ACT_STAY,
        ACT_GOTO,
        ACT_OPEN_OBJ,
        ACT_OPEN_ARR,
        ACT_CLOSE_OBJ,
        ACT_CLOSE_ARR,
        ACT_COMMA,
        ACT_FAIL,
        ACT_LIT_START,
        ACT_LIT_STEP
    } act_t;

    // one queued byte with its class
    typedef struct packed {
        logic [7:0]  data_byte;
        byte_class_t cls;
        logic        last;
    } item_t;

    // back to stack
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        kind_t kind;
    } stk_cmd_t;

    // stack to back
    typedef struct packed {
        logic  empty;
        logic  full;
        logic  single;
        kind_t tos;
    } stk_stat_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        c = CLS_OTHER;
        priority if (b == CHR_SPACE || b == CHR_LF || b == CHR_CR || b == CHR_TAB)
            c = CLS_WS;
        else if (b >= CHR_ZERO && b <= CHR_NINE)
            c = CLS_DIGIT;
        else if (b == CHR_LBRACE)
            c = CLS_OBJ_OPEN;
        else if (b == CHR_RBRACE)
            c = CLS_OBJ_CLOSE;
        else if (b == CHR_LBRACK)
            c = CLS_ARR_OPEN;
        else if (b == CHR_RBRACK)
            c = CLS_ARR_CLOSE;
        else if (b == CHR_QUOTE)
            c = CLS_QUOTE;
        else if (b == CHR_COMMA)
            c = CLS_COMMA;
        else if (b == CHR_COLON)
            c = CLS_COLON;
        else if (b == CHR_T)
            c = CLS_LIT_T;
        else if (b == CHR_F)
            c = CLS_LIT_F;
        else if (b == CHR_N)
            c = CLS_LIT_N;
        else
            c = CLS_OTHER;
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input lit_kind_t k);
        logic [2:0] n;
        unique case (k)
            LIT_TRUE:  n = 3'd4;
            LIT_FALSE: n = 3'd5;
            LIT_NULL:  n = 3'd4;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] lit_char(input lit_kind_t k, input logic [2:0] pos);
        logic [7:0] c;
        c = CHR_NUL;
        unique case (k)
            LIT_TRUE:
            begin
                unique case (pos)
                    3'd0:    c = CHR_T;
                    3'd1:    c = CHR_R;
                    3'd2:    c = CHR_U;
                    3'd3:    c = CHR_E;
                    default: c = CHR_NUL;
                endcase
            end
            LIT_FALSE:
            begin
                unique case (pos)
                    3'd0:    c = CHR_F;
                    3'd1:    c = CHR_A;
                    3'd2:    c = CHR_L;
                    3'd3:    c = CHR_S;
                    3'd4:    c = CHR_E;
                    default: c = CHR_NUL;
                endcase
            end
            LIT_NULL:
            begin
                unique case (pos)
                    3'd0:    c = CHR_N;
                    3'd1:    c = CHR_U;
                    3'd2:    c = CHR_L;
                    3'd3:    c = CHR_L;
                    default: c = CHR_NUL;
                endcase
            end
            default: c = CHR_NUL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/jsv_front.sv
// front end: accepts bytes, classifies them and queues them for the parser
`default_nettype none

module jsv_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          last,
    output logic               q_valid,
    output jsv_pkg::item_t     q_item,
    input  wire logic          q_pop
);

    localparam int unsigned PW = (jsv_pkg::QUEUE_DEPTH > 1) ? $clog2(jsv_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(jsv_pkg::QUEUE_DEPTH + 1);

    jsv_pkg::item_t q_reg [jsv_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push;
    logic           pop;

    assign in_stall = (count_reg == CW'(jsv_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = CW'(count_reg + 1'b1);
            2'b01:   count_next = CW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // classify on the way in
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{data_byte: data_byte,
                                   cls:       jsv_pkg::classify(data_byte),
                                   last:      last};
        end
    end

endmodule

`default_nettype wire

>>> rtl/jsv_stack.sv
// container stack: memory of kinds with top and next-below held in registers
`default_nettype none

module jsv_stack #(
    parameter int unsigned MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  jsv_pkg::stk_cmd_t   cmd,
    output jsv_pkg::stk_stat_t  stat
);

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic           mem [MAX_DEPTH];
    logic [DW-1:0]  depth_reg, depth_next;
    jsv_pkg::kind_t tos_reg;
    jsv_pkg::kind_t below_reg;
    logic           do_push;
    logic           do_pop;
    logic           rd_en;
    logic [DW-1:0]  depth_less3;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    assign stat.empty  = (depth_reg == '0);
    assign stat.full   = (depth_reg == DW'(MAX_DEPTH));
    assign stat.single = (depth_reg == DW'(1));
    assign stat.tos    = tos_reg;

    assign do_push     = cmd.push && !stat.full && !cmd.clear;
    assign do_pop      = cmd.pop && !stat.empty && !cmd.clear;
    // after a pop from depth d the new below entry sits at d-3
    assign rd_en       = do_pop && (int'(depth_reg) >= 3);
    assign depth_less3 = DW'(int'(depth_reg) - 3);
    assign rd_addr     = depth_less3[AW-1:0];
    assign wr_addr     = depth_reg[AW-1:0];

    always_comb
    begin
        priority if (cmd.clear)
            depth_next = '0;
        else if (do_push)
            depth_next = DW'(depth_reg + 1'b1);
        else if (do_pop)
            depth_next = DW'(depth_reg - 1'b1);
        else
            depth_next = depth_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= '0;
        else
            depth_reg <= depth_next;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_addr] <= cmd.kind;
        if (rd_en)
            below_reg <= jsv_pkg::kind_t'(mem[rd_addr]);
        else if (do_push)
            below_reg <= tos_reg;
        if (do_push)
            tos_reg <= cmd.kind;
        else if (do_pop)
            tos_reg <= below_reg;
    end

endmodule

`default_nettype wire

>>> rtl/jsv_back.sv
// back end: parse state machine, stack control and result register
`default_nettype none

module jsv_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  jsv_pkg::item_t      q_item,
    output logic                q_pop,
    output jsv_pkg::stk_cmd_t   stk_cmd,
    input  jsv_pkg::stk_stat_t  stk_stat,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic                valid_res,
    output logic                depth_overflow
);

    jsv_pkg::phase_t    phase_reg, phase_next;
    jsv_pkg::lit_kind_t lit_kind_reg, lit_kind_next;
    logic [2:0]         lit_pos_reg, lit_pos_next;
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;
    logic               ovf_reg, ovf_next;
    logic               out_valid_reg, out_valid_next;
    logic               valid_res_reg, valid_res_next;
    logic               depth_overflow_reg, depth_overflow_next;

    jsv_pkg::act_t      act;
    jsv_pkg::phase_t    goto_phase;
    jsv_pkg::act_t      sv_act;
    jsv_pkg::phase_t    sv_phase;
    logic               take;
    logic               take_last;
    logic               consume;
    logic [2:0]         lit_pos_inc;

    assign q_pop          = q_valid && (!q_item.last || !out_valid_reg || !out_stall);
    assign take           = q_pop;
    assign take_last      = take && q_item.last;
    assign consume        = take && !done_reg;
    assign lit_pos_inc    = 3'(lit_pos_reg + 1'b1);
    assign out_valid      = out_valid_reg;
    assign valid_res      = valid_res_reg;
    assign depth_overflow = depth_overflow_reg;

    // start of a value
    always_comb
    begin
        sv_phase = phase_reg;
        unique case (q_item.cls)
            jsv_pkg::CLS_OBJ_OPEN: sv_act = jsv_pkg::ACT_OPEN_OBJ;
            jsv_pkg::CLS_ARR_OPEN: sv_act = jsv_pkg::ACT_OPEN_ARR;
            jsv_pkg::CLS_QUOTE:
            begin
                sv_act   = jsv_pkg::ACT_GOTO;
                sv_phase = jsv_pkg::PH_IN_STRING;
            end
            jsv_pkg::CLS_DIGIT:
            begin
                sv_act   = jsv_pkg::ACT_GOTO;
                sv_phase = jsv_pkg::PH_NUMBER;
            end
            jsv_pkg::CLS_LIT_T,
            jsv_pkg::CLS_LIT_F,
            jsv_pkg::CLS_LIT_N:    sv_act = jsv_pkg::ACT_LIT_START;
            default:               sv_act = jsv_pkg::ACT_FAIL;
        endcase
    end

    // decode: what this byte does in the current phase
    always_comb
    begin
        act        = jsv_pkg::ACT_STAY;
        goto_phase = phase_reg;
        unique case (phase_reg)
            jsv_pkg::PH_TOP:
            begin
                priority if (q_item.cls == jsv_pkg::CLS_WS)
                    act = jsv_pkg::ACT_STAY;
                else if (q_item.cls == jsv_pkg::CLS_OBJ_OPEN)
                    act = jsv_pkg::ACT_OPEN_OBJ;
                else if (q_item.cls == jsv_pkg::CLS_ARR_OPEN)
                    act = jsv_pkg::ACT_OPEN_ARR;
                else
                    act = jsv_pkg::ACT_FAIL;
            end
            jsv_pkg::PH_ARR_FIRST:
            begin
                priority if (q_item.cls == jsv_pkg::CLS_WS)
                    act = jsv_pkg::ACT_STAY;
                else if (q_item.cls == jsv_pkg::CLS_ARR_CLOSE)
                    act = jsv_pkg::ACT_CLOSE_ARR;
                else
                begin
                    act        = sv_act;
                    goto_phase = sv_phase;
                end
            end
            jsv_pkg::PH_ARR_COMMA:
            begin
                // trailing comma only when the bracket follows directly
                priority if (q_item.cls == jsv_pkg::CLS_ARR_CLOSE)
                    act = jsv_pkg::ACT_CLOSE_ARR;
                else if (q_item.cls == jsv_pkg::CLS_WS)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_VALUE;
                end
                else
                begin
                    act        = sv_act;
                    goto_phase = sv_phase;
                end
            end
            jsv_pkg::PH_VALUE:
            begin
                if (q_item.cls == jsv_pkg::CLS_WS)
                    act = jsv_pkg::ACT_STAY;
                else
                begin
                    act        = sv_act;
                    goto_phase = sv_phase;
                end
            end
            jsv_pkg::PH_OBJ_FIRST:
            begin
                priority if (q_item.cls == jsv_pkg::CLS_WS)
                    act = jsv_pkg::ACT_STAY;
                else if (q_item.cls == jsv_pkg::CLS_OBJ_CLOSE)
                    act = jsv_pkg::ACT_CLOSE_OBJ;
                else if (q_item.cls == jsv_pkg::CLS_QUOTE)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_IN_KEY;
                end
                else
                    act = jsv_pkg::ACT_FAIL;
            end
            jsv_pkg::PH_OBJ_COMMA:
            begin
                priority if (q_item.cls == jsv_pkg::CLS_OBJ_CLOSE)
                    act = jsv_pkg::ACT_CLOSE_OBJ;
                else if (q_item.cls == jsv_pkg::CLS_WS)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_KEY;
                end
                else if (q_item.cls == jsv_pkg::CLS_QUOTE)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_IN_KEY;
                end
                else
                    act = jsv_pkg::ACT_FAIL;
            end
            jsv_pkg::PH_KEY:
            begin
                priority if (q_item.cls == jsv_pkg::CLS_WS)
                    act = jsv_pkg::ACT_STAY;
                else if (q_item.cls == jsv_pkg::CLS_QUOTE)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_IN_KEY;
                end
                else
                    act = jsv_pkg::ACT_FAIL;
            end
            jsv_pkg::PH_IN_KEY:
            begin
                if (q_item.cls == jsv_pkg::CLS_QUOTE)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_COLON;
                end
            end
            jsv_pkg::PH_COLON:
            begin
                if (q_item.cls == jsv_pkg::CLS_COLON)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_VALUE;
                end
                else
                    act = jsv_pkg::ACT_FAIL;
            end
            jsv_pkg::PH_IN_STRING:
            begin
                if (q_item.cls == jsv_pkg::CLS_QUOTE)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_AFTER;
                end
            end
            jsv_pkg::PH_LITERAL:
                act = jsv_pkg::ACT_LIT_STEP;
            jsv_pkg::PH_NUMBER,
            jsv_pkg::PH_AFTER:
            begin
                // a number ends at the first non-digit, which is then handled as after a value
                priority if (q_item.cls == jsv_pkg::CLS_DIGIT &&
                             phase_reg == jsv_pkg::PH_NUMBER)
                    act = jsv_pkg::ACT_STAY;
                else if (q_item.cls == jsv_pkg::CLS_WS)
                begin
                    act        = jsv_pkg::ACT_GOTO;
                    goto_phase = jsv_pkg::PH_AFTER;
                end
                else if (q_item.cls == jsv_pkg::CLS_COMMA)
                    act = jsv_pkg::ACT_COMMA;
                else if (q_item.cls == jsv_pkg::CLS_ARR_CLOSE)
                    act = jsv_pkg::ACT_CLOSE_ARR;
                else if (q_item.cls == jsv_pkg::CLS_OBJ_CLOSE)
                    act = jsv_pkg::ACT_CLOSE_OBJ;
                else
                    act = jsv_pkg::ACT_FAIL;
            end
            default: act = jsv_pkg::ACT_FAIL;
        endcase
    end

    // next state, stack command and result
    always_comb
    begin
        phase_next          = phase_reg;
        lit_kind_next       = lit_kind_reg;
        lit_pos_next        = lit_pos_reg;
        done_next           = done_reg;
        ok_next             = ok_reg;
        ovf_next            = ovf_reg;
        stk_cmd             = '{push: 1'b0, pop: 1'b0, clear: 1'b0, kind: jsv_pkg::KIND_OBJ};
        valid_res_next      = valid_res_reg;
        depth_overflow_next = depth_overflow_reg;

        if (consume)
        begin
            unique case (act)
                jsv_pkg::ACT_STAY: ;
                jsv_pkg::ACT_GOTO: phase_next = goto_phase;
                jsv_pkg::ACT_OPEN_OBJ,
                jsv_pkg::ACT_OPEN_ARR:
                begin
                    if (stk_stat.full)
                    begin
                        ovf_next  = 1'b1;
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                    end
                    else
                    begin
                        stk_cmd.push = 1'b1;
                        if (act == jsv_pkg::ACT_OPEN_ARR)
                        begin
                            stk_cmd.kind = jsv_pkg::KIND_ARR;
                            phase_next   = jsv_pkg::PH_ARR_FIRST;
                        end
                        else
                        begin
                            stk_cmd.kind = jsv_pkg::KIND_OBJ;
                            phase_next   = jsv_pkg::PH_OBJ_FIRST;
                        end
                    end
                end
                jsv_pkg::ACT_CLOSE_OBJ,
                jsv_pkg::ACT_CLOSE_ARR:
                begin
                    if (stk_stat.empty ||
                        (stk_stat.tos == jsv_pkg::KIND_ARR) != (act == jsv_pkg::ACT_CLOSE_ARR))
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                    end
                    else
                    begin
                        stk_cmd.pop = 1'b1;
                        if (stk_stat.single)
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b1;
                        end
                        else
                            phase_next = jsv_pkg::PH_AFTER;
                    end
                end
                jsv_pkg::ACT_COMMA:
                begin
                    if (stk_stat.empty)
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                    end
                    else if (stk_stat.tos == jsv_pkg::KIND_ARR)
                        phase_next = jsv_pkg::PH_ARR_COMMA;
                    else
                        phase_next = jsv_pkg::PH_OBJ_COMMA;
                end
                jsv_pkg::ACT_LIT_START:
                begin
                    unique case (q_item.cls)
                        jsv_pkg::CLS_LIT_T: lit_kind_next = jsv_pkg::LIT_TRUE;
                        jsv_pkg::CLS_LIT_F: lit_kind_next = jsv_pkg::LIT_FALSE;
                        default:            lit_kind_next = jsv_pkg::LIT_NULL;
                    endcase
                    lit_pos_next = 3'd1;
                    phase_next   = jsv_pkg::PH_LITERAL;
                end
                jsv_pkg::ACT_LIT_STEP:
                begin
                    if (lit_pos_reg >= jsv_pkg::lit_len(lit_kind_reg) ||
                        q_item.data_byte != jsv_pkg::lit_char(lit_kind_reg, lit_pos_reg))
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                    end
                    else if (lit_pos_inc >= jsv_pkg::lit_len(lit_kind_reg))
                    begin
                        lit_pos_next = '0;
                        phase_next   = jsv_pkg::PH_AFTER;
                    end
                    else
                        lit_pos_next = lit_pos_inc;
                end
                default:
                begin
                    done_next = 1'b1;
                    ok_next   = 1'b0;
                end
            endcase
        end

        // end of message: report and start over
        if (take_last)
        begin
            valid_res_next      = done_next && ok_next;
            depth_overflow_next = ovf_next;
            phase_next          = jsv_pkg::PH_TOP;
            lit_kind_next       = jsv_pkg::LIT_TRUE;
            lit_pos_next        = '0;
            done_next           = 1'b0;
            ok_next             = 1'b0;
            ovf_next            = 1'b0;
            stk_cmd.clear       = 1'b1;
        end
    end

    always_comb
    begin
        if (take_last)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jsv_pkg::PH_TOP;
            lit_kind_reg  <= jsv_pkg::LIT_TRUE;
            lit_pos_reg   <= '0;
            done_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            lit_kind_reg  <= lit_kind_next;
            lit_pos_reg   <= lit_pos_next;
            done_reg      <= done_next;
            ok_reg        <= ok_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg      <= valid_res_next;
        depth_overflow_reg <= depth_overflow_next;
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stk_cmd.push |-> !stk_stat.full)
        else $error("push issued on a full stack");

    a_push_pop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(stk_cmd.push && stk_cmd.pop))
        else $error("push and pop in the same cycle");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take_last |=> (phase_reg == jsv_pkg::PH_TOP && !done_reg && !ovf_reg && out_valid_reg))
        else $error("state not restarted after final byte");

    a_overflow_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(valid_res_reg && depth_overflow_reg))
        else $error("overflow reported with a valid verdict");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(take_last))
        else $error("result appeared without a final byte");

endmodule

`default_nettype wire

>>> rtl/json_syntax_validator_unit.sv
// top level of the json syntax validator: front queue, parser back end and stack
`default_nettype none

// usage
//   input channel: one message byte per transfer on data_byte, with last set on
//   the final byte. a transfer happens when in_valid is high and in_stall is low.
//   output channel: one result per message, valid_res and depth_overflow, moved
//   when out_valid is high and out_stall is low.
// timing
//   a byte is classified and written to a four-entry queue on its transfer; the
//   parser takes it the next cycle at the earliest and registers the result of
//   a message as it takes its last byte. throughput is one byte per cycle while
//   no result waits, set by the parser step and the one-read stack memory.
// stack
//   the container stack is a MAX_DEPTH by one bit memory with its top and the
//   entry below it held in registers; its contents need no clearing.
// reset
//   rst_n clears the queue, parse state, stack depth and out_valid, not the
//   result values; the block takes bytes as soon as reset ends.
// stall
//   while a result waits under out_stall the parser keeps taking bytes of the
//   next message and halts only on its last byte; the queue fills and then
//   in_stall rises.
module json_syntax_validator_unit #(
    parameter int unsigned MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            valid_res,
    output logic            depth_overflow
);

    // queue between classifier and parser
    logic               q_valid;
    logic               q_pop;
    jsv_pkg::item_t     q_item;

    // parser to stack control and status
    jsv_pkg::stk_cmd_t  stk_cmd;
    jsv_pkg::stk_stat_t stk_stat;

    jsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last      (last),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    jsv_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .stk_cmd        (stk_cmd),
        .stk_stat       (stk_stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .valid_res      (valid_res),
        .depth_overflow (depth_overflow)
    );

    jsv_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .stat  (stk_stat)
    );

endmodule

`default_nettype wire
